// ----- sv/kfpv_pkg.sv -----
// Shared types, constants and the micro-program for the position/velocity Kalman filter.
// Used by the controller, the datapath and the top level; depends on nothing.
package kfpv_pkg;

  localparam int DW       = 32;          // data word, signed Q16.16
  localparam int FB       = 16;          // fraction bits
  localparam int CFG_W    = 31;          // width of the unsigned config words
  localparam int RF_DEPTH = 16;
  localparam int RA_W     = 4;
  localparam int SRC_W    = 5;
  localparam int PC_W     = 6;
  localparam int MAG_W    = DW + FB + 1; // magnitude before clamping
  localparam int DIV_STEPS = DW + FB;    // quotient bits from the serial divider

  localparam logic [DW-1:0] INIT_VAR_BOOT = DW'(1000) << FB;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOV, OP_CLR, OP_LDI, OP_LDK,
    OP_BRD, OP_END, OP_HALT
  } op_t;

  typedef enum logic [2:0] {
    CFG_STEP_TIME, CFG_MEAS_VAR, CFG_PROC_VAR_POS, CFG_PROC_COV_POS_VEL,
    CFG_PROC_VAR_VEL, CFG_INIT_VAR
  } cfg_idx_t;

  // operand and destination codes: below 16 is the scratch RAM
  localparam logic [SRC_W-1:0] R_X0   = 5'd0;
  localparam logic [SRC_W-1:0] R_X1   = 5'd1;
  localparam logic [SRC_W-1:0] R_P00  = 5'd2;
  localparam logic [SRC_W-1:0] R_P01  = 5'd3;
  localparam logic [SRC_W-1:0] R_P11  = 5'd4;
  localparam logic [SRC_W-1:0] R_T    = 5'd5;
  localparam logic [SRC_W-1:0] R_A00  = 5'd6;
  localparam logic [SRC_W-1:0] R_A01  = 5'd7;
  localparam logic [SRC_W-1:0] R_PP00 = 5'd8;
  localparam logic [SRC_W-1:0] R_PP01 = 5'd9;
  localparam logic [SRC_W-1:0] R_PP11 = 5'd10;
  localparam logic [SRC_W-1:0] R_XP0  = 5'd11;
  localparam logic [SRC_W-1:0] R_S    = 5'd12;
  localparam logic [SRC_W-1:0] R_K0   = 5'd13;
  localparam logic [SRC_W-1:0] R_K1   = 5'd14;
  localparam logic [SRC_W-1:0] R_Y    = 5'd15;
  localparam logic [SRC_W-1:0] R_DT   = 5'd16;
  localparam logic [SRC_W-1:0] R_RV   = 5'd17;
  localparam logic [SRC_W-1:0] R_Q00  = 5'd18;
  localparam logic [SRC_W-1:0] R_Q01  = 5'd19;
  localparam logic [SRC_W-1:0] R_Q11  = 5'd20;
  localparam logic [SRC_W-1:0] R_Z    = 5'd21;

  localparam logic [PC_W-1:0] PC_RESTART = 6'd0;
  localparam logic [PC_W-1:0] PC_MAIN    = 6'd5;
  localparam logic [PC_W-1:0] PC_DEGEN   = 6'd32;
  localparam logic [PC_W-1:0] PC_BOOT    = 6'd37;

  typedef struct packed {
    op_t              op;
    logic [SRC_W-1:0] dst;
    logic [SRC_W-1:0] a;
    logic [SRC_W-1:0] b;
  } uinstr_t;

  typedef struct packed {
    logic    start;
    uinstr_t ins;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic s_nonpos;
  } dp_stat_t;

  typedef struct packed {
    logic take_item;
    logic out_load;
    logic degen;
  } dp_ctl_t;

  function automatic uinstr_t mk(op_t op, logic [SRC_W-1:0] d, logic [SRC_W-1:0] a,
                                 logic [SRC_W-1:0] b);
    uinstr_t u;
    u.op  = op;
    u.dst = d;
    u.a   = a;
    u.b   = b;
    return u;
  endfunction

  function automatic uinstr_t urom(logic [PC_W-1:0] pc);
    uinstr_t u;
    case (pc)
      // restart: reload state and covariance
      6'd0:  u = mk(OP_CLR, R_X0, R_T, R_T);
      6'd1:  u = mk(OP_CLR, R_X1, R_T, R_T);
      6'd2:  u = mk(OP_LDI, R_P00, R_T, R_T);
      6'd3:  u = mk(OP_CLR, R_P01, R_T, R_T);
      6'd4:  u = mk(OP_LDI, R_P11, R_T, R_T);
      // predict
      6'd5:  u = mk(OP_MUL, R_T, R_DT, R_P01);
      6'd6:  u = mk(OP_ADD, R_A00, R_P00, R_T);
      6'd7:  u = mk(OP_MUL, R_T, R_DT, R_P11);
      6'd8:  u = mk(OP_ADD, R_A01, R_P01, R_T);
      6'd9:  u = mk(OP_MUL, R_T, R_DT, R_A01);
      6'd10: u = mk(OP_ADD, R_T, R_A00, R_T);
      6'd11: u = mk(OP_ADD, R_PP00, R_T, R_Q00);
      6'd12: u = mk(OP_ADD, R_PP01, R_A01, R_Q01);
      6'd13: u = mk(OP_ADD, R_PP11, R_P11, R_Q11);
      6'd14: u = mk(OP_MUL, R_T, R_DT, R_X1);
      6'd15: u = mk(OP_ADD, R_XP0, R_X0, R_T);
      6'd16: u = mk(OP_ADD, R_S, R_PP00, R_RV);
      6'd17: u = mk(OP_BRD, R_T, R_T, R_T);
      // update
      6'd18: u = mk(OP_DIV, R_K0, R_PP00, R_S);
      6'd19: u = mk(OP_DIV, R_K1, R_PP01, R_S);
      6'd20: u = mk(OP_SUB, R_Y, R_Z, R_XP0);
      6'd21: u = mk(OP_MUL, R_T, R_K0, R_Y);
      6'd22: u = mk(OP_ADD, R_X0, R_XP0, R_T);
      6'd23: u = mk(OP_MUL, R_T, R_K1, R_Y);
      6'd24: u = mk(OP_ADD, R_X1, R_X1, R_T);
      6'd25: u = mk(OP_MUL, R_T, R_K0, R_PP00);
      6'd26: u = mk(OP_SUB, R_P00, R_PP00, R_T);
      6'd27: u = mk(OP_MUL, R_T, R_K0, R_PP01);
      6'd28: u = mk(OP_SUB, R_P01, R_PP01, R_T);
      6'd29: u = mk(OP_MUL, R_T, R_K1, R_PP01);
      6'd30: u = mk(OP_SUB, R_P11, R_PP11, R_T);
      6'd31: u = mk(OP_END, R_T, R_T, R_T);
      // innovation variance not positive: keep the prediction
      6'd32: u = mk(OP_MOV, R_X0, R_XP0, R_T);
      6'd33: u = mk(OP_MOV, R_P00, R_PP00, R_T);
      6'd34: u = mk(OP_MOV, R_P01, R_PP01, R_T);
      6'd35: u = mk(OP_MOV, R_P11, R_PP11, R_T);
      6'd36: u = mk(OP_END, R_T, R_T, R_T);
      // after reset
      6'd37: u = mk(OP_CLR, R_X0, R_T, R_T);
      6'd38: u = mk(OP_CLR, R_X1, R_T, R_T);
      6'd39: u = mk(OP_LDK, R_P00, R_T, R_T);
      6'd40: u = mk(OP_CLR, R_P01, R_T, R_T);
      6'd41: u = mk(OP_LDK, R_P11, R_T, R_T);
      default: u = mk(OP_HALT, R_T, R_T, R_T);
    endcase
    return u;
  endfunction

endpackage

// ----- sv/kalman_filter_pos_vel.sv -----
// Two-state constant-velocity Kalman filter, signed Q16.16, one result per request.
// One item at a time: a new request is taken only once the previous one is done; the
// update is skipped if the innovation variance is not positive; restart reloads the state.
// A new request is taken while the previous result waits in the output register.
// Reset (rst_n, synchronous) restores the register defaults, then runs the boot program
// loading the initial state into the scratch RAM before the first request is taken.
module kalman_filter_pos_vel (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] meas_pos
  input  logic [0:0]   in_tuser,   // [0] restart
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // est_pos, est_vel, var_pos, cov_pos_vel, var_vel
  output logic [1:0]   out_tuser,  // [0] degenerate, [1] saturated
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_data
);

  kfpv_pkg::dp_cmd_t  cmd;
  kfpv_pkg::dp_ctl_t  ctl;
  kfpv_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  kfpv_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_restart (in_tuser[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .ctl        (ctl),
    .stat       (stat)
  );

  kfpv_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .ctl       (ctl),
    .stat      (stat),
    .in_meas   (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

// ----- sv/kfpv_ram.sv -----
// Generic RAM: one write port, two read ports with registered data.
// No dependencies.
module kfpv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ----- sv/kfpv_ctrl.sv -----
// Controller: steps the micro-program, runs the input and output handshakes.
// Depends on kfpv_pkg.
module kfpv_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               in_restart,
  output logic               out_tvalid,
  input  logic               out_tready,
  output kfpv_pkg::dp_cmd_t  cmd,
  output kfpv_pkg::dp_ctl_t  ctl,
  input  kfpv_pkg::dp_stat_t stat
);

  typedef enum logic [1:0] {C_IDLE, C_FETCH, C_WAIT, C_DONE} cstate_t;

  cstate_t                     state_r, state_nxt;
  logic [kfpv_pkg::PC_W-1:0]   pc_r, pc_nxt;
  logic                        degen_r, degen_nxt;
  logic                        out_valid_r, out_valid_nxt;
  kfpv_pkg::uinstr_t           ins;
  logic                        take;
  logic                        load;

  assign ins       = kfpv_pkg::urom(pc_r);
  assign in_tready = (state_r == C_IDLE);
  assign take      = in_tvalid && in_tready;
  assign load      = (state_r == C_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    cmd.ins   = ins;
    cmd.start = 1'b0;
    if (state_r == C_FETCH) begin
      case (ins.op)
        kfpv_pkg::OP_BRD, kfpv_pkg::OP_END, kfpv_pkg::OP_HALT: cmd.start = 1'b0;
        default: cmd.start = 1'b1;
      endcase
    end
  end

  assign ctl.take_item = take;
  assign ctl.out_load  = load;
  assign ctl.degen     = degen_r;
  assign out_tvalid    = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    degen_nxt     = degen_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      C_IDLE: begin
        if (take) begin
          pc_nxt    = in_restart ? kfpv_pkg::PC_RESTART : kfpv_pkg::PC_MAIN;
          degen_nxt = 1'b0;
          state_nxt = C_FETCH;
        end
      end
      C_FETCH: begin
        case (ins.op)
          kfpv_pkg::OP_BRD: begin
            if (stat.s_nonpos) begin
              pc_nxt    = kfpv_pkg::PC_DEGEN;
              degen_nxt = 1'b1;
            end else begin
              pc_nxt = pc_r + kfpv_pkg::PC_W'(1);
            end
          end
          kfpv_pkg::OP_END:  state_nxt = C_DONE;
          kfpv_pkg::OP_HALT: state_nxt = C_IDLE;
          default:           state_nxt = C_WAIT;
        endcase
      end
      C_WAIT: begin
        if (stat.done) begin
          pc_nxt    = pc_r + kfpv_pkg::PC_W'(1);
          state_nxt = C_FETCH;
        end
      end
      C_DONE: begin
        // hold the finished result until the output register is free
        if (load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = C_IDLE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= C_FETCH;
      pc_r        <= kfpv_pkg::PC_BOOT;
      degen_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      degen_r     <= degen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- sv/kfpv_dp.sv -----
// Datapath: config registers, scratch RAM, saturating adder, shared multiplier,
// bit-serial divider and the output register. Depends on kfpv_pkg and kfpv_ram.
module kfpv_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  kfpv_pkg::dp_cmd_t        cmd,
  input  kfpv_pkg::dp_ctl_t        ctl,
  output kfpv_pkg::dp_stat_t       stat,
  input  logic [kfpv_pkg::DW-1:0]  in_meas,
  input  logic                     cfg_valid,
  input  logic [2:0]               cfg_addr,
  input  logic [31:0]              cfg_data,
  output logic [5*kfpv_pkg::DW-1:0] out_tdata,
  output logic [1:0]               out_tuser
);

  localparam int DW = kfpv_pkg::DW;
  localparam int FB = kfpv_pkg::FB;
  localparam int MW = kfpv_pkg::MAG_W;
  localparam int NW = kfpv_pkg::DIV_STEPS;
  localparam int CW = $clog2(kfpv_pkg::DIV_STEPS);
  localparam logic [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [2:0] {DP_IDLE, DP_OPER, DP_MUL, DP_DIV, DP_DIVR} dphase_t;

  typedef struct packed {
    logic          sat;
    logic [DW-1:0] v;
  } res_t;

  function automatic res_t clamp_mag(logic [MW-1:0] mag, logic neg);
    res_t r;
    logic [MW-1:0] lim;
    lim = (MW'(1) << (DW - 1)) - (neg ? MW'(0) : MW'(1));
    if (mag > lim) begin
      r.sat = 1'b1;
      r.v   = neg ? VMIN : VMAX;
    end else begin
      r.sat = 1'b0;
      r.v   = neg ? -mag[DW-1:0] : mag[DW-1:0];
    end
    return r;
  endfunction

  function automatic res_t add_sat(logic [DW-1:0] a, logic [DW-1:0] b, logic sub);
    res_t r;
    logic [DW:0] s;
    s = sub ? ({a[DW-1], a} - {b[DW-1], b}) : ({a[DW-1], a} + {b[DW-1], b});
    if (s[DW] != s[DW-1]) begin
      r.sat = 1'b1;
      r.v   = s[DW] ? VMIN : VMAX;
    end else begin
      r.sat = 1'b0;
      r.v   = s[DW-1:0];
    end
    return r;
  endfunction

  logic [kfpv_pkg::CFG_W-1:0] step_time_r, meas_var_r, proc_var_pos_r;
  logic [kfpv_pkg::CFG_W-1:0] proc_var_vel_r, init_var_r;
  logic [DW-1:0]              proc_cov_r;
  logic [DW-1:0]              z_r;

  dphase_t         phase_r;
  logic [DW-1:0]   ram_a, ram_b, op_a, op_b;
  logic [DW-1:0]   mag_a, mag_b;
  logic [2*DW-1:0] prod_r;
  logic            neg_r;
  logic [NW-1:0]   num_r, quo_r;
  logic [DW-1:0]   den_r, rem_r;
  logic [CW-1:0]   cnt_r;
  logic [DW:0]     rem_sh;
  logic            rem_ge;
  logic [2*DW:0]   rnd_prod;
  logic [MW-1:0]   quo_rnd;

  logic            wr_en;
  logic [DW-1:0]   wr_data;
  logic            wr_sat;
  res_t            res;
  logic            sat_r, s_nonpos_r;
  logic [DW-1:0]   sh_x0_r, sh_x1_r, sh_p00_r, sh_p01_r, sh_p11_r;
  logic [5*DW-1:0] out_tdata_r;
  logic [1:0]      out_tuser_r;

  kfpv_ram #(.WIDTH(DW), .DEPTH(kfpv_pkg::RF_DEPTH)) u_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (cmd.ins.dst[kfpv_pkg::RA_W-1:0]),
    .wdata   (wr_data),
    .raddr_a (cmd.ins.a[kfpv_pkg::RA_W-1:0]),
    .raddr_b (cmd.ins.b[kfpv_pkg::RA_W-1:0]),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  function automatic logic [DW-1:0] pick(logic [kfpv_pkg::SRC_W-1:0] src,
                                         logic [DW-1:0] ram);
    logic [DW-1:0] v;
    case (src)
      kfpv_pkg::R_DT:  v = DW'(step_time_r);
      kfpv_pkg::R_RV:  v = DW'(meas_var_r);
      kfpv_pkg::R_Q00: v = DW'(proc_var_pos_r);
      kfpv_pkg::R_Q01: v = proc_cov_r;
      kfpv_pkg::R_Q11: v = DW'(proc_var_vel_r);
      kfpv_pkg::R_Z:   v = z_r;
      default:         v = ram;
    endcase
    return v;
  endfunction

  assign op_a  = pick(cmd.ins.a, ram_a);
  assign op_b  = pick(cmd.ins.b, ram_b);
  assign mag_a = op_a[DW-1] ? -op_a : op_a;
  assign mag_b = op_b[DW-1] ? -op_b : op_b;

  // one restoring step of the divider, and rounding of the product and the quotient
  assign rem_sh   = {rem_r, num_r[NW-1]};
  assign rem_ge   = rem_sh >= {1'b0, den_r};
  assign rnd_prod = {1'b0, prod_r} + ((2*DW+1)'(1) << (FB - 1));
  assign quo_rnd  = {1'b0, quo_r} + MW'(rem_r >= (den_r - rem_r));

  always_comb begin
    wr_en   = 1'b0;
    wr_data = '0;
    wr_sat  = 1'b0;
    res     = '0;
    case (phase_r)
      DP_OPER: begin
        case (cmd.ins.op)
          kfpv_pkg::OP_ADD, kfpv_pkg::OP_SUB: begin
            res     = add_sat(op_a, op_b, cmd.ins.op == kfpv_pkg::OP_SUB);
            wr_en   = 1'b1;
            wr_data = res.v;
            wr_sat  = res.sat;
          end
          kfpv_pkg::OP_MOV: begin
            wr_en   = 1'b1;
            wr_data = op_a;
          end
          kfpv_pkg::OP_CLR: wr_en = 1'b1;
          kfpv_pkg::OP_LDI: begin
            wr_en   = 1'b1;
            wr_data = DW'(init_var_r);
          end
          kfpv_pkg::OP_LDK: begin
            wr_en   = 1'b1;
            wr_data = kfpv_pkg::INIT_VAR_BOOT;
          end
          default: wr_en = 1'b0;
        endcase
      end
      DP_MUL: begin
        res     = clamp_mag(MW'(rnd_prod >> FB), neg_r);
        wr_en   = 1'b1;
        wr_data = res.v;
        wr_sat  = res.sat;
      end
      DP_DIVR: begin
        res     = clamp_mag(quo_rnd, neg_r);
        wr_en   = 1'b1;
        wr_data = res.v;
        wr_sat  = res.sat;
      end
      default: wr_en = 1'b0;
    endcase
  end

  assign stat.done     = wr_en;
  assign stat.s_nonpos = s_nonpos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= DP_IDLE;
      step_time_r    <= kfpv_pkg::CFG_W'(65536);
      meas_var_r     <= kfpv_pkg::CFG_W'(65536);
      proc_var_pos_r <= '0;
      proc_cov_r     <= '0;
      proc_var_vel_r <= '0;
      init_var_r     <= kfpv_pkg::CFG_W'(65536000);
      sat_r          <= 1'b0;
      s_nonpos_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (kfpv_pkg::cfg_idx_t'(cfg_addr))
          kfpv_pkg::CFG_STEP_TIME:        step_time_r    <= cfg_data[kfpv_pkg::CFG_W-1:0];
          kfpv_pkg::CFG_MEAS_VAR:         meas_var_r     <= cfg_data[kfpv_pkg::CFG_W-1:0];
          kfpv_pkg::CFG_PROC_VAR_POS:     proc_var_pos_r <= cfg_data[kfpv_pkg::CFG_W-1:0];
          kfpv_pkg::CFG_PROC_COV_POS_VEL: proc_cov_r     <= cfg_data[DW-1:0];
          kfpv_pkg::CFG_PROC_VAR_VEL:     proc_var_vel_r <= cfg_data[kfpv_pkg::CFG_W-1:0];
          kfpv_pkg::CFG_INIT_VAR:         init_var_r     <= cfg_data[kfpv_pkg::CFG_W-1:0];
          default: ;
        endcase
      end
      if (ctl.take_item) begin
        sat_r <= 1'b0;
      end else if (wr_en) begin
        sat_r <= sat_r | wr_sat;
      end
      if (wr_en && cmd.ins.op == kfpv_pkg::OP_ADD) begin
        s_nonpos_r <= wr_data[DW-1] || (wr_data == '0);
      end
      case (phase_r)
        DP_IDLE: if (cmd.start) phase_r <= DP_OPER;
        DP_OPER: begin
          case (cmd.ins.op)
            kfpv_pkg::OP_MUL: phase_r <= DP_MUL;
            kfpv_pkg::OP_DIV: phase_r <= DP_DIV;
            default:          phase_r <= DP_IDLE;
          endcase
        end
        DP_DIV:  if (cnt_r == '0) phase_r <= DP_DIVR;
        default: phase_r <= DP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take_item) begin
      z_r <= in_meas;
    end
    if (phase_r == DP_OPER) begin
      prod_r <= (2*DW)'(mag_a) * (2*DW)'(mag_b);
      neg_r  <= op_a[DW-1] ^ (op_b[DW-1] && cmd.ins.op == kfpv_pkg::OP_MUL);
      num_r  <= {mag_a, {FB{1'b0}}};
      den_r  <= op_b;
      rem_r  <= '0;
      quo_r  <= '0;
      cnt_r  <= CW'(NW - 1);
    end else if (phase_r == DP_DIV) begin
      rem_r <= rem_ge ? DW'(rem_sh - {1'b0, den_r}) : rem_sh[DW-1:0];
      quo_r <= {quo_r[NW-2:0], rem_ge};
      num_r <= {num_r[NW-2:0], 1'b0};
      cnt_r <= cnt_r - CW'(1);
    end
    // mirror the state words for the output register
    if (wr_en) begin
      case (cmd.ins.dst)
        kfpv_pkg::R_X0:  sh_x0_r  <= wr_data;
        kfpv_pkg::R_X1:  sh_x1_r  <= wr_data;
        kfpv_pkg::R_P00: sh_p00_r <= wr_data;
        kfpv_pkg::R_P01: sh_p01_r <= wr_data;
        kfpv_pkg::R_P11: sh_p11_r <= wr_data;
        default: ;
      endcase
    end
    if (ctl.out_load) begin
      out_tdata_r <= {sh_p11_r, sh_p01_r, sh_p00_r, sh_x1_r, sh_x0_r};
      out_tuser_r <= {sat_r, ctl.degen};
    end
  end

  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

endmodule
